[rtl/brsre_pkg.sv]
// Shared constants and types of the binary row short-run eraser.
`default_nettype none

package brsre_pkg;

    localparam int CHUNK_BITS = 16;
    localparam int IDX_W      = 4;
    localparam int LIMIT_W    = 8;

    localparam logic [LIMIT_W-1:0] RUN_LIMIT_RESET = 8'd30;

    // Queue status seen by the loader and by the scanner.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

`default_nettype wire

[rtl/brsre_if.sv]
// Handshake channels for pixel items and chunk items.
`default_nettype none

interface brsre_pix_if;
    logic valid;
    logic ready;
    logic pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface brsre_chunk_if;
    import brsre_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CHUNK_BITS-1:0] chunk;
    logic [IDX_W-1:0]      chunk_index;
    logic                  last_chunk;

    modport source (output valid, output chunk, output chunk_index, output last_chunk,
                    input ready);
    modport sink (input valid, input chunk, input chunk_index, input last_chunk,
                  output ready);
endinterface

`default_nettype wire

[rtl/binary_row_short_run_eraser.sv]
// Top level of the binary row short-run eraser.
//
//  channel   dir   handshake          payload
//  pixels    in    valid / ready      pixel (1 bit)
//  chunks    out   valid / ready      chunk (16), chunk_index (4), last_chunk (1)
//  cfg       in    cfg_we             cfg_wdata (8) -> run_limit
//
// Pixels are taken one per cycle while the two-row queue has room; only the
// pixel that completes a row waits when the queue is full.
// The scanner handles a row in a left scan and a right scan, each over every
// column, then sends its chunks; it takes a new row only once the last chunk
// of the previous row has been loaded into the output register.
// A stalled chunk holds in the output register; reset clears control state.
`default_nettype none

module binary_row_short_run_eraser #(
    parameter int COLS = 128
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_we,
    input  wire  [brsre_pkg::LIMIT_W-1:0]  cfg_wdata,
    brsre_pix_if.sink                      pixels,
    brsre_chunk_if.source                  chunks
);
    import brsre_pkg::*;

    logic [LIMIT_W-1:0] run_limit_reg;
    logic [COLS-1:0]    push_row;
    logic [COLS-1:0]    head_row;
    logic               push;
    logic               pop;
    fifo_stat_t         stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_limit_reg <= RUN_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            run_limit_reg <= cfg_wdata;
        end
    end

    brsre_front #(
        .COLS (COLS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .stat   (stat),
        .push   (push),
        .row    (push_row)
    );

    brsre_row_fifo #(
        .WIDTH (COLS)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (push_row),
        .pop   (pop),
        .rdata (head_row),
        .stat  (stat)
    );

    brsre_back #(
        .COLS (COLS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_limit (run_limit_reg),
        .stat      (stat),
        .head      (head_row),
        .pop       (pop),
        .chunks    (chunks)
    );

endmodule

`default_nettype wire

[rtl/brsre_row_fifo.sv]
// Two-entry queue of complete rows between the loader and the scanner.
`default_nettype none

module brsre_row_fifo #(
    parameter int WIDTH = 128
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     push,
    input  wire  [WIDTH-1:0]        wdata,
    input  wire                     pop,
    output logic [WIDTH-1:0]        rdata,
    output brsre_pkg::fifo_stat_t   stat
);
    import brsre_pkg::*;

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign rdata      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("row pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("row popped from an empty queue");

endmodule

`default_nettype wire

[rtl/brsre_front.sv]
// Loader: shifts pixel items into a row and hands each full row to the queue.
`default_nettype none

module brsre_front #(
    parameter int COLS = 128
) (
    input  wire                     clk,
    input  wire                     rst_n,
    brsre_pix_if.sink               pixels,
    input  brsre_pkg::fifo_stat_t   stat,
    output logic                    push,
    output logic [COLS-1:0]         row
);
    import brsre_pkg::*;

    localparam int IDXW = $clog2(COLS);
    localparam logic [IDXW-1:0] LAST_COL = IDXW'(COLS - 1);

    logic [COLS-1:0] row_reg;
    logic [COLS-1:0] row_next;
    logic [IDXW-1:0] col_reg;
    logic [IDXW-1:0] col_next;
    logic            accept;

    // Only the pixel that completes a row has to wait for room in the queue.
    assign pixels.ready = (col_reg != LAST_COL) || !stat.full;
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        push     = 1'b0;
        if (accept)
        begin
            // The newest pixel enters at the top, so column k ends up at bit k.
            row_next = {pixels.pixel, row_reg[COLS-1:1]};
            if (col_reg == LAST_COL)
            begin
                col_next = '0;
                push     = 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    assign row = row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

endmodule

`default_nettype wire

[rtl/brsre_back.sv]
// Scanner: left and right run scans over a stored row, then chunked output.
`default_nettype none

module brsre_back #(
    parameter int COLS = 128
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [brsre_pkg::LIMIT_W-1:0]    run_limit,
    input  brsre_pkg::fifo_stat_t            stat,
    input  wire  [COLS-1:0]                  head,
    output logic                             pop,
    brsre_chunk_if.source                    chunks
);
    import brsre_pkg::*;

    localparam int IDXW       = $clog2(COLS);
    localparam int CMPW       = (IDXW > LIMIT_W) ? IDXW : LIMIT_W;
    localparam int NUM_CHUNKS = (COLS + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PADW       = NUM_CHUNKS * CHUNK_BITS;
    localparam logic [IDXW-1:0]  LAST_K      = IDXW'(COLS - 1);
    localparam logic [IDXW-1:0]  LEFT_END    = IDXW'(COLS - 1);
    localparam logic [IDXW-1:0]  RIGHT_END   = IDXW'(COLS - 2);
    localparam logic [IDX_W-1:0] LAST_CHUNK  = IDX_W'(NUM_CHUNKS - 1);
    localparam logic [COLS-1:0]  LEFT_MARK   = {{(COLS-1){1'b0}}, 1'b1};
    localparam logic [COLS-1:0]  RIGHT_MARK  = {2'b01, {(COLS-2){1'b0}}};

    typedef enum logic [5:0] {
        B_IDLE   = 6'b000001,
        B_LEFT   = 6'b000010,
        B_LAPPLY = 6'b000100,
        B_RIGHT  = 6'b001000,
        B_RAPPLY = 6'b010000,
        B_SEND   = 6'b100000
    } back_state_t;

    typedef enum logic [3:0] {
        PH_SEEK_A = 4'b0001,
        PH_SEEK_C = 4'b0010,
        PH_FOUND  = 4'b0100,
        PH_NONE   = 4'b1000
    } phase_t;

    back_state_t           state_reg;
    back_state_t           state_next;
    phase_t                ph_reg;
    phase_t                ph_next;
    logic [COLS-1:0]       w_reg;
    logic [COLS-1:0]       w_next;
    logic [COLS-1:0]       m_reg;
    logic [COLS-1:0]       m_next;
    logic [IDXW-1:0]       k_reg;
    logic [IDXW-1:0]       k_next;
    logic [IDXW-1:0]       cnt_reg;
    logic [IDXW-1:0]       cnt_next;
    logic [PADW-1:0]       sr_reg;
    logic [PADW-1:0]       sr_next;
    logic [IDX_W-1:0]      sidx_reg;
    logic [IDX_W-1:0]      sidx_next;
    logic                  ovalid_reg;
    logic [CHUNK_BITS-1:0] ochunk_reg;
    logic [IDX_W-1:0]      oidx_reg;
    logic                  olast_reg;
    logic                  mark;
    logic                  erase;
    logic                  load;
    logic [COLS-1:0]       m_mark;
    logic [COLS-1:0]       w_clean;

    assign erase   = (ph_reg == PH_FOUND) && (CMPW'(cnt_reg) < CMPW'(run_limit));
    assign w_clean = erase ? (w_reg & ~m_reg) : w_reg;
    assign load    = (state_reg == B_SEND) && (!ovalid_reg || chunks.ready);

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        w_next     = w_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        sr_next    = sr_reg;
        sidx_next  = sidx_reg;
        pop        = 1'b0;
        mark       = 1'b0;
        m_mark     = m_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!stat.empty)
                begin
                    pop        = 1'b1;
                    w_next     = head;
                    m_next     = '0;
                    k_next     = '0;
                    cnt_next   = '0;
                    ph_next    = PH_SEEK_A;
                    state_next = B_LEFT;
                end
            end
            B_LEFT:
            begin
                // The row rotates right; bits 0 and 1 hold columns k and k+1.
                if (k_reg < LEFT_END)
                begin
                    case (ph_reg)
                        PH_SEEK_A:
                        begin
                            if (!w_reg[0] && w_reg[1])
                            begin
                                if (k_reg == '0)
                                begin
                                    ph_next = PH_NONE;
                                end
                                else
                                begin
                                    ph_next  = PH_SEEK_C;
                                    mark     = 1'b1;
                                    cnt_next = IDXW'(1);
                                end
                            end
                        end
                        PH_SEEK_C:
                        begin
                            mark     = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                            if (w_reg[0] && !w_reg[1])
                            begin
                                ph_next = PH_FOUND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                m_mark = mark ? (m_reg | LEFT_MARK) : m_reg;
                w_next = {w_reg[0], w_reg[COLS-1:1]};
                m_next = {m_mark[0], m_mark[COLS-1:1]};
                k_next = k_reg + 1'b1;
                if (k_reg == LAST_K)
                begin
                    state_next = B_LAPPLY;
                end
            end
            B_LAPPLY:
            begin
                // After a full turn the row and the mark are aligned again.
                w_next     = w_clean;
                m_next     = '0;
                k_next     = '0;
                cnt_next   = '0;
                ph_next    = PH_SEEK_A;
                state_next = B_RIGHT;
            end
            B_RIGHT:
            begin
                // The row rotates left; the two top bits hold columns c and c-1,
                // and the marked column is always c-1.
                if (k_reg < RIGHT_END)
                begin
                    case (ph_reg)
                        PH_SEEK_A:
                        begin
                            if (!w_reg[COLS-1] && w_reg[COLS-2])
                            begin
                                ph_next  = PH_SEEK_C;
                                mark     = 1'b1;
                                cnt_next = IDXW'(1);
                            end
                        end
                        PH_SEEK_C:
                        begin
                            mark     = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                            if (w_reg[COLS-1] && !w_reg[COLS-2])
                            begin
                                ph_next = PH_FOUND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                m_mark = mark ? (m_reg | RIGHT_MARK) : m_reg;
                w_next = {w_reg[COLS-2:0], w_reg[COLS-1]};
                m_next = {m_mark[COLS-2:0], m_mark[COLS-1]};
                k_next = k_reg + 1'b1;
                if (k_reg == LAST_K)
                begin
                    state_next = B_RAPPLY;
                end
            end
            B_RAPPLY:
            begin
                sr_next    = PADW'(w_clean);
                sidx_next  = '0;
                m_next     = '0;
                state_next = B_SEND;
            end
            B_SEND:
            begin
                if (load)
                begin
                    sr_next   = sr_reg >> CHUNK_BITS;
                    sidx_next = sidx_reg + 1'b1;
                    if (sidx_reg == LAST_CHUNK)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            ph_reg     <= PH_SEEK_A;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            if (load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (chunks.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        m_reg    <= m_next;
        k_reg    <= k_next;
        cnt_reg  <= cnt_next;
        sr_reg   <= sr_next;
        sidx_reg <= sidx_next;
        if (load)
        begin
            ochunk_reg <= sr_reg[CHUNK_BITS-1:0];
            oidx_reg   <= sidx_reg;
            olast_reg  <= (sidx_reg == LAST_CHUNK);
        end
    end

    assign chunks.valid       = ovalid_reg;
    assign chunks.chunk       = ochunk_reg;
    assign chunks.chunk_index = oidx_reg;
    assign chunks.last_chunk  = olast_reg;

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (chunks.valid && chunks.last_chunk) |-> (chunks.chunk_index == LAST_CHUNK))
        else $error("last chunk flagged at a wrong index");

    a_left_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LEFT && k_reg == LAST_K) |=> (state_reg == B_LAPPLY))
        else $error("left scan did not end after one full turn");

    a_mark_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_LAPPLY) |=> (m_reg == '0 && k_reg == '0))
        else $error("right scan started with a stale mark or count");

endmodule

`default_nettype wire
